>>> hw/rtl/fdpu_pkg.sv
// Shared types, constants and codes for the frame delta updater.
package fdpu_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 32;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;

    localparam int COLOR_W   = 32;
    localparam int PEND_W    = COLOR_W + 1;
    localparam int CFG_ADDR_W = 4;

    localparam logic [6:0] MAX_W_CFG = 7'(MAX_WIDTH);
    localparam logic [6:0] MAX_H_CFG = 7'(MAX_HEIGHT);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

    localparam logic [6:0]  WIDTH_RESET  = 7'd64;
    localparam logic [5:0]  HEIGHT_RESET = 6'd32;
    localparam logic [31:0] BLANK_RESET  = 32'd0;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_COMMIT = 1'b1;

    typedef enum logic [1:0] {
        REG_ACTIVE_WIDTH  = 2'd0,
        REG_ACTIVE_HEIGHT = 2'd1,
        REG_BLANK_COLOR   = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic       func;
        logic [6:0] x_coord;
        logic [5:0] y_coord;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
        logic       clear_previous;
    } in_item_t;

    typedef struct packed {
        logic [5:0] x_out;
        logic [4:0] y_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_change;
    } out_item_t;

    typedef struct packed {
        logic      push;
        logic      flush;
        out_item_t item;
    } emit_ctl_t;

    typedef struct packed {
        logic can_push;
        logic hold_empty;
    } emit_sts_t;

endpackage

>>> hw/rtl/fdpu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fdpu_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/fdpu_emit.sv
// Result hold stage and output register; marks the final change of a row.
module fdpu_emit import fdpu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  emit_ctl_t ctl,
    output emit_sts_t sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      hold_vld_reg, hold_vld_next;
    out_item_t hold_reg, hold_next;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_reg, out_next;
    logic      out_free;

    // a change waits in hold until we know whether another one follows
    assign out_free     = !out_vld_reg || m_ready;
    assign sts.can_push = !hold_vld_reg || out_free;
    assign sts.hold_empty = !hold_vld_reg;

    always_comb begin
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        out_next      = out_reg;
        if (ctl.push && sts.can_push) begin
            if (hold_vld_reg) begin
                out_vld_next = 1'b1;
                out_next     = hold_reg;
                out_next.last_change = 1'b0;
            end
            hold_vld_next = 1'b1;
            hold_next     = ctl.item;
        end else if (ctl.flush && hold_vld_reg && out_free) begin
            out_vld_next  = 1'b1;
            out_next      = hold_reg;
            out_next.last_change = 1'b1;
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    a_no_push_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.push && ctl.flush))
        else $error("push and flush requested together");

    a_flush_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.flush && hold_vld_reg && out_free) |=> (out_vld_reg && out_reg.last_change))
        else $error("flushed change not marked last");

    a_push_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.push && hold_vld_reg && out_free) |=> !out_reg.last_change)
        else $error("change followed by another marked last");

endmodule

>>> hw/rtl/frame_diff_pixel_updater_core.sv
// Top level: config registers, clear pass, row scan over pending and shown stores.
//
//  channel | ports                   | carries
//  --------+-------------------------+---------------------------------------
//  in      | s_valid/s_ready/s_data  | pixel write or row commit request
//  out     | m_valid/m_ready/m_data  | one changed pixel, last_change on final
//  cfg     | psel/penable/pwrite/... | active_width, active_height, blank_color
//
//  Pixel write: written into the pending RAM at the accept edge.
//  Row commit: one column per cycle through the registered RAM read, held
//  back while a changed column finds the hold register full and the output
//  register full and not taken; the last change is then flushed.
//  After reset a clearing pass over all 2**ADDR_W (2048) addresses zeroes
//  both RAMs; s_ready stays low during it.
//  Output stalls only stall the scan and flush; a new request is taken once both end.
module frame_diff_pixel_updater_core import fdpu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    state_t state_reg, state_next;

    logic [6:0]  active_width_reg;
    logic [5:0]  active_height_reg;
    logic [31:0] blank_color_reg;
    logic [6:0]  eff_w;
    logic [6:0]  eff_h;
    cfg_reg_t    cfg_sel;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              clr_prev_reg;
    logic [COL_W-1:0]  rd_col_reg;
    logic              rd_pending_reg;
    logic [COL_W-1:0]  e_col_reg;
    logic              e_vld_reg;

    logic in_fire, wr_ok, commit_ok, rd_issue, e_fire, scan_done;
    logic e_in_w, e_mark, e_changed;
    logic [COLOR_W-1:0] e_pcolor, e_old, e_new;

    logic               p_we, s_we;
    logic [ADDR_W-1:0]  p_waddr, s_waddr, rd_addr, e_addr;
    logic [PEND_W-1:0]  p_wdata, p_rdata;
    logic [COLOR_W-1:0] s_wdata, s_rdata;

    emit_ctl_t emit_ctl;
    emit_sts_t emit_sts;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_width_reg  <= WIDTH_RESET;
            active_height_reg <= HEIGHT_RESET;
            blank_color_reg   <= BLANK_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_sel)
                REG_ACTIVE_WIDTH:  active_width_reg  <= pwdata[6:0];
                REG_ACTIVE_HEIGHT: active_height_reg <= pwdata[5:0];
                REG_BLANK_COLOR:   blank_color_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_ACTIVE_WIDTH:  prdata = {25'd0, active_width_reg};
            REG_ACTIVE_HEIGHT: prdata = {26'd0, active_height_reg};
            REG_BLANK_COLOR:   prdata = blank_color_reg;
            default:           prdata = 32'd0;
        endcase
    end

    assign eff_w = (active_width_reg > MAX_W_CFG) ? MAX_W_CFG : active_width_reg;
    assign eff_h = ({1'b0, active_height_reg} > MAX_H_CFG) ? MAX_H_CFG
                                                           : {1'b0, active_height_reg};

    // ---------------- request decode ----------------
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign wr_ok     = in_fire && (s_data.func == FUNC_WRITE) &&
                       (s_data.x_coord < eff_w) && ({1'b0, s_data.y_coord} < eff_h);
    assign commit_ok = in_fire && (s_data.func == FUNC_COMMIT) &&
                       ({1'b0, s_data.y_coord} < eff_h);

    // ---------------- scan pipeline ----------------
    assign e_addr   = {row_reg, e_col_reg};
    assign rd_addr  = {row_reg, rd_col_reg};
    assign e_mark   = p_rdata[PEND_W-1];
    assign e_pcolor = p_rdata[COLOR_W-1:0];
    assign e_old    = s_rdata;
    assign e_in_w   = {1'b0, e_col_reg} < eff_w;

    always_comb begin
        if (e_mark) begin
            e_new = e_pcolor;
        end else if (clr_prev_reg) begin
            e_new = blank_color_reg;
        end else begin
            e_new = e_old;
        end
    end

    assign e_changed = e_vld_reg && e_in_w && (e_new != e_old);
    assign e_fire    = e_vld_reg && (!e_changed || emit_sts.can_push);
    // read data stays in the RAM output register while the stage is stalled
    assign rd_issue  = (state_reg == ST_SCAN) && rd_pending_reg && (!e_vld_reg || e_fire);
    assign scan_done = e_fire && !rd_pending_reg && (e_col_reg == LAST_COL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pending_reg <= 1'b0;
            e_vld_reg      <= 1'b0;
            clr_cnt_reg    <= '0;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (commit_ok) begin
                rd_pending_reg <= 1'b1;
            end else if (rd_issue && (rd_col_reg == LAST_COL)) begin
                rd_pending_reg <= 1'b0;
            end
            if (rd_issue) begin
                e_vld_reg <= 1'b1;
            end else if (e_fire) begin
                e_vld_reg <= 1'b0;
            end
        end
        if (commit_ok) begin
            row_reg      <= s_data.y_coord[ROW_W-1:0];
            clr_prev_reg <= s_data.clear_previous;
            rd_col_reg   <= '0;
        end else if (rd_issue) begin
            rd_col_reg <= rd_col_reg + 1'b1;
        end
        if (rd_issue) begin
            e_col_reg <= rd_col_reg;
        end
    end

    // ---------------- state machine ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (commit_ok) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (emit_sts.hold_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        p_we    = 1'b0;
        p_waddr = e_addr;
        p_wdata = {1'b0, e_pcolor};
        s_we    = 1'b0;
        s_waddr = e_addr;
        s_wdata = e_new;
        emit_ctl.push  = 1'b0;
        emit_ctl.flush = 1'b0;
        emit_ctl.item.x_out       = 6'(e_col_reg);
        emit_ctl.item.y_out       = 5'(row_reg);
        emit_ctl.item.red_out     = e_new[31:24];
        emit_ctl.item.green_out   = e_new[23:16];
        emit_ctl.item.blue_out    = e_new[15:8];
        emit_ctl.item.alpha_out   = e_new[7:0];
        emit_ctl.item.last_change = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = clr_cnt_reg;
                p_wdata = '0;
                s_we    = 1'b1;
                s_waddr = clr_cnt_reg;
                s_wdata = '0;
            end
            ST_IDLE: begin
                p_we    = wr_ok;
                p_waddr = {s_data.y_coord[ROW_W-1:0], s_data.x_coord[COL_W-1:0]};
                p_wdata = {1'b1, s_data.red_in, s_data.green_in,
                           s_data.blue_in, s_data.alpha_in};
            end
            ST_SCAN: begin
                // every column drops its set mark; only changes touch shown
                p_we          = e_fire;
                s_we          = e_fire && e_changed;
                emit_ctl.push = e_changed;
            end
            ST_FLUSH: begin
                emit_ctl.flush = 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- stores and output ----------------
    fdpu_ram #(.DATA_W(PEND_W), .ADDR_W(ADDR_W)) u_pending (
        .aclk    (aclk),
        .wr_en   (p_we),
        .wr_addr (p_waddr),
        .wr_data (p_wdata),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr),
        .rd_data (p_rdata)
    );

    fdpu_ram #(.DATA_W(COLOR_W), .ADDR_W(ADDR_W)) u_shown (
        .aclk    (aclk),
        .wr_en   (s_we),
        .wr_addr (s_waddr),
        .wr_data (s_wdata),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr),
        .rd_data (s_rdata)
    );

    fdpu_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (emit_ctl),
        .sts     (emit_sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ---------------- checks ----------------
    a_pipe_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_vld_reg || rd_pending_reg) |-> (state_reg == ST_SCAN))
        else $error("scan pipeline busy outside of a row scan");

    a_issue_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |=> (e_vld_reg && (e_col_reg == $past(rd_col_reg))))
        else $error("read issue did not load the compare stage");

    a_stall_holds_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_vld_reg && !e_fire) |=> (e_vld_reg && $stable(e_col_reg)))
        else $error("stalled column lost");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !(s_valid && s_ready))
        else $error("request accepted during a row scan");

endmodule
